### rtl/assert_macros.svh
// Assertion shorthands for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define MJDC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mjdc assertion failed");

// Checked on every rising edge, reset included.
`define MJDC_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mjdc reset assertion failed");

`endif

### rtl/mjdc_pkg.sv
`default_nettype none

package mjdc_pkg;

    localparam int MJD_W  = 16;
    localparam int TIME_W = 24;
    localparam int BIN_W  = 8;
    localparam int N_W    = 20;   // 20*mjd - 301564 for the whole valid range
    localparam int YR_W   = 8;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int K_W    = 9;    // mjd - floor(1461*y/4) - 14956 stays within 123..488
    localparam int NUM_M  = 1 << MON_W;

    localparam logic [MJD_W-1:0] MJD_FIRST_VALID = 16'd15079;

    // Year: floor((20*mjd - 301564) / 7305) via reciprocal and one correction
    localparam logic [N_W-1:0] Y_NUM_OFS = 20'd301564;
    localparam int             Y_DIV     = 7305;
    localparam int             Y_SHIFT   = 32;
    localparam int             P_W       = 2 * N_W;
    localparam logic [N_W-1:0] Y_RECIP   = N_W'((64'd1 << Y_SHIFT) / 64'(Y_DIV));
    localparam int             LIM_W     = N_W + 1;

    localparam int             YD_MUL    = 1461;
    localparam int             YD_W      = 18;
    localparam logic [16:0]    DAY_OFS   = 17'd14956;

    // Month: 30.6001 and the 0.1 of 14956.1 scaled by 10000
    localparam int M_SCALE = 10000;
    localparam int M_STEP  = 306001;
    localparam int M_BIAS  = 1000;

    localparam logic [MON_W-1:0] MON_WRAP_LO = 4'd14;
    localparam logic [MON_W-1:0] MON_WRAP_HI = 4'd15;
    localparam logic [MON_W-1:0] MON_WRAP_SUB = 4'd13;

    typedef logic [NUM_M-1:0][K_W-1:0] t_k_tab;

    // Smallest k with 10000*k - 1000 >= 306001*j
    function automatic t_k_tab thr_init();
        t_k_tab t;
        t = '0;
        for (int j = 1; j < NUM_M; j++) begin
            t[j] = K_W'((M_STEP * j + M_BIAS + M_SCALE - 1) / M_SCALE);
        end
        return t;
    endfunction

    // floor(306001*m / 10000)
    function automatic t_k_tab mofs_init();
        t_k_tab t;
        t = '0;
        for (int j = 0; j < NUM_M; j++) begin
            t[j] = K_W'((M_STEP * j) / M_SCALE);
        end
        return t;
    endfunction

    localparam t_k_tab M_THR = thr_init();
    localparam t_k_tab M_OFS = mofs_init();

    function automatic logic [BIN_W-1:0] bcd_to_bin(input logic [7:0] b);
        return BIN_W'({b[7:4], 3'b000}) + BIN_W'({b[7:4], 1'b0}) + BIN_W'(b[3:0]);
    endfunction

    typedef struct packed {
        logic [BIN_W-1:0] hour;
        logic [BIN_W-1:0] minute;
        logic [BIN_W-1:0] second;
        logic             date_ok;
    } t_side;

    typedef struct packed {
        logic [N_W-1:0]   n;
        logic [MJD_W-1:0] mjd;
        t_side            side;
    } t_front;

    typedef struct packed {
        logic [YR_W-1:0]  q0;
        logic [N_W-1:0]   n;
        logic [MJD_W-1:0] mjd;
        t_side            side;
    } t_quot;

    typedef struct packed {
        logic [YR_W-1:0]  y;
        logic [MJD_W-1:0] mjd;
        t_side            side;
    } t_yr;

    typedef struct packed {
        logic [YR_W-1:0] y;
        logic [K_W-1:0]  k;
        t_side           side;
    } t_kq;

    typedef struct packed {
        logic [YR_W-1:0]  y;
        logic [MON_W-1:0] m;
        logic [K_W-1:0]   k;
        t_side            side;
    } t_mq;

    typedef struct packed {
        logic [YR_W-1:0]  year;
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
        t_side            side;
    } t_cal;

endpackage

`default_nettype wire

### rtl/mjdc_bcd_time_to_calendar_top.sv
// Converts a Modified Julian Date and a BCD time of day into calendar year
// (from 1900), month, day and binary hour, minute and second, using the
// broadcast Annex C formula in exact integer form. One transaction is taken
// every cycle while o_stall is low. The six register stages are input
// scaling and BCD decode, the year reciprocal multiply, its correction,
// the day-of-year offset, the month threshold count, and the day and
// year-wrap output stage. Each stage holds its own valid bit, so bubbles
// close up under output stall and o_stall rises only once every stage is
// full. Dates before MJD 15079 come out as zero with o_date_valid low; the
// time fields are still decoded, and a nibble above 9 is taken literally.
`default_nettype none
`include "assert_macros.svh"

module mjd_bcd_time_to_calendar_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic [mjdc_pkg::MJD_W-1:0]   i_mjd,
    input  wire logic [mjdc_pkg::TIME_W-1:0]  i_bcd_time,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [mjdc_pkg::YR_W-1:0]         o_year_from_1900,
    output logic [mjdc_pkg::MON_W-1:0]        o_month,
    output logic [mjdc_pkg::DAY_W-1:0]        o_day,
    output logic                              o_date_valid,
    output logic [mjdc_pkg::BIN_W-1:0]        o_hour,
    output logic [mjdc_pkg::BIN_W-1:0]        o_minute,
    output logic [mjdc_pkg::BIN_W-1:0]        o_second
);
    import mjdc_pkg::*;

    logic           r_f_v;
    t_front         r_f;
    t_front         n_f;
    logic           s_f_stall;
    logic           s_yd_stall;
    logic           s_yd_v;
    t_yr            s_yd;
    logic           s_md_stall;
    logic           s_md_v;
    t_cal           s_md;
    logic [N_W:0]   s_n20;

    assign s_f_stall = r_f_v && s_yd_stall;

    always_comb begin
        s_n20               = (N_W+1)'({i_mjd, 4'b0000}) + (N_W+1)'({i_mjd, 2'b00});
        n_f.n               = s_n20[N_W-1:0] - Y_NUM_OFS;
        n_f.mjd             = i_mjd;
        n_f.side.date_ok    = (i_mjd >= MJD_FIRST_VALID);
        n_f.side.hour       = bcd_to_bin(i_bcd_time[23:16]);
        n_f.side.minute     = bcd_to_bin(i_bcd_time[15:8]);
        n_f.side.second     = bcd_to_bin(i_bcd_time[7:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (!s_f_stall) begin
            r_f_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_f_stall && i_valid) r_f <= n_f;
    end

    mjdc_ydiv u_ydiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_v),
        .i_data  (r_f),
        .o_stall (s_yd_stall),
        .o_valid (s_yd_v),
        .o_data  (s_yd),
        .i_stall (s_md_stall)
    );

    mjdc_mday u_mday (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_yd_v),
        .i_data  (s_yd),
        .o_stall (s_md_stall),
        .o_valid (s_md_v),
        .o_data  (s_md),
        .i_stall (i_stall)
    );

    assign o_stall          = s_f_stall;
    assign o_valid          = s_md_v;
    assign o_year_from_1900 = s_md.year;
    assign o_month          = s_md.month;
    assign o_day            = s_md.day;
    assign o_date_valid     = s_md.side.date_ok;
    assign o_hour           = s_md.side.hour;
    assign o_minute         = s_md.side.minute;
    assign o_second         = s_md.side.second;

    // input back-pressure only ever comes from a held result
    `MJDC_ASSERT(a_stall_src, i_clk, i_rst_n, o_stall |-> o_valid)
    `MJDC_ASSERT(a_inval_zero, i_clk, i_rst_n,
        (o_valid && !o_date_valid) |-> ({o_year_from_1900, o_month, o_day} == '0))
    `MJDC_ASSERT(a_date_range, i_clk, i_rst_n,
        (o_valid && o_date_valid) |-> (o_month >= 4'd1 && o_month <= 4'd12 && o_day != '0))
    `MJDC_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid)

endmodule

`default_nettype wire

### rtl/mjdc_ydiv.sv
`default_nettype none

// Year count: reciprocal multiply, then one compare to fix the low quotient.
module mjdc_ydiv (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire mjdc_pkg::t_front i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output mjdc_pkg::t_yr        o_data,
    input  wire logic            i_stall
);
    import mjdc_pkg::*;

    logic             r_a_v;
    t_quot            r_a;
    t_quot            n_a;
    logic             r_b_v;
    t_yr              r_b;
    t_yr              n_b;
    logic             s_a_stall;
    logic             s_b_stall;
    logic [P_W-1:0]   s_prod;
    logic [LIM_W-1:0] s_lim;

    assign s_b_stall = r_b_v && i_stall;
    assign s_a_stall = r_a_v && s_b_stall;

    always_comb begin
        s_prod     = P_W'(i_data.n) * P_W'(Y_RECIP);
        n_a.q0     = s_prod[Y_SHIFT +: YR_W];
        n_a.n      = i_data.n;
        n_a.mjd    = i_data.mjd;
        n_a.side   = i_data.side;
    end

    // estimate is never high and at most one low
    always_comb begin
        s_lim    = (LIM_W'(r_a.q0) + LIM_W'(1)) * LIM_W'(Y_DIV);
        n_b.y    = r_a.q0 + YR_W'(LIM_W'(r_a.n) >= s_lim);
        n_b.mjd  = r_a.mjd;
        n_b.side = r_a.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (!s_a_stall) r_a_v <= i_valid;
            if (!s_b_stall) r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_a_stall && i_valid) r_a <= n_a;
        if (!s_b_stall && r_a_v)   r_b <= n_b;
    end

    assign o_stall = s_a_stall;
    assign o_valid = r_b_v;
    assign o_data  = r_b;

endmodule

`default_nettype wire

### rtl/mjdc_mday.sv
`default_nettype none

// Day offset within the year, month by threshold count, day and year wrap.
module mjdc_mday (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire mjdc_pkg::t_yr   i_data,
    output logic                 o_stall,
    output logic                 o_valid,
    output mjdc_pkg::t_cal       o_data,
    input  wire logic            i_stall
);
    import mjdc_pkg::*;

    logic             r_a_v;
    t_kq              r_a;
    t_kq              n_a;
    logic             r_b_v;
    t_mq              r_b;
    t_mq              n_b;
    logic             r_c_v;
    t_cal             r_c;
    t_cal             n_c;
    logic             s_a_stall;
    logic             s_b_stall;
    logic             s_c_stall;
    logic [YD_W-1:0]  s_yd;
    logic [16:0]      s_k;
    logic [K_W:0]     s_diff;

    assign s_c_stall = r_c_v && i_stall;
    assign s_b_stall = r_b_v && s_c_stall;
    assign s_a_stall = r_a_v && s_b_stall;

    always_comb begin
        s_yd     = YD_W'(i_data.y) * YD_W'(YD_MUL);
        s_k      = 17'(i_data.mjd) - 17'(s_yd >> 2) - DAY_OFS;
        n_a.y    = i_data.y;
        n_a.k    = s_k[K_W-1:0];
        n_a.side = i_data.side;
    end

    // thresholds rise with the month, so the count is the month index
    always_comb begin
        n_b.m = '0;
        for (int j = 1; j < NUM_M; j++) begin
            n_b.m = n_b.m + MON_W'(r_a.k >= M_THR[j]);
        end
        n_b.y    = r_a.y;
        n_b.k    = r_a.k;
        n_b.side = r_a.side;
    end

    always_comb begin
        s_diff = {1'b0, r_b.k} - {1'b0, M_OFS[r_b.m]};
        n_c.side = r_b.side;
        if (!r_b.side.date_ok) begin
            n_c.year  = '0;
            n_c.month = '0;
            n_c.day   = '0;
        end else begin
            n_c.day = (s_diff[K_W] || s_diff == '0) ? '0 : s_diff[DAY_W-1:0];
            if (r_b.m == MON_WRAP_LO || r_b.m == MON_WRAP_HI) begin
                n_c.year  = r_b.y + YR_W'(1);
                n_c.month = r_b.m - MON_WRAP_SUB;
            end else begin
                n_c.year  = r_b.y;
                n_c.month = (r_b.m != '0) ? r_b.m - MON_W'(1) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (!s_a_stall) r_a_v <= i_valid;
            if (!s_b_stall) r_b_v <= r_a_v;
            if (!s_c_stall) r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!s_a_stall && i_valid) r_a <= n_a;
        if (!s_b_stall && r_a_v)   r_b <= n_b;
        if (!s_c_stall && r_b_v)   r_c <= n_c;
    end

    assign o_stall = s_a_stall;
    assign o_valid = r_c_v;
    assign o_data  = r_c;

endmodule

`default_nettype wire

### bench/mjd_bcd_time_to_calendar_top_tb.sv
`default_nettype none

module mjd_bcd_time_to_calendar_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mjdc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [YR_W-1:0]  year;
        logic [MON_W-1:0] month;
        logic [DAY_W-1:0] day;
        logic             date_ok;
        logic [BIN_W-1:0] hour;
        logic [BIN_W-1:0] minute;
        logic [BIN_W-1:0] second;
    } t_exp_cal;

    logic                i_clk;
    logic                i_rst_n    = 1'b0;
    logic                i_valid    = 1'b0;
    logic [MJD_W-1:0]    i_mjd      = '0;
    logic [TIME_W-1:0]   i_bcd_time = '0;
    logic                i_stall    = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [YR_W-1:0]     o_year_from_1900;
    logic [MON_W-1:0]    o_month;
    logic [DAY_W-1:0]    o_day;
    logic                o_date_valid;
    logic [BIN_W-1:0]    o_hour;
    logic [BIN_W-1:0]    o_minute;
    logic [BIN_W-1:0]    o_second;

    t_exp_cal    pending_dates[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          quiet_mode     = 1'b0;

    mjd_bcd_time_to_calendar_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mjd            (i_mjd),
        .i_bcd_time       (i_bcd_time),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_year_from_1900 (o_year_from_1900),
        .o_month          (o_month),
        .o_day            (o_day),
        .o_date_valid     (o_date_valid),
        .o_hour           (o_hour),
        .o_minute         (o_minute),
        .o_second         (o_second)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // nibbles above 9 are taken at face value
    function automatic logic [BIN_W-1:0] decode_bcd_byte(input logic [7:0] b);
        int tens;
        int units;
        tens  = int'(b[7:4]);
        units = int'(b[3:0]);
        return BIN_W'(tens * 10 + units);
    endfunction

    // Annex C date conversion, fractional constants scaled to integers
    function automatic t_exp_cal predict_calendar(input logic [MJD_W-1:0] mjd,
                                                  input logic [TIME_W-1:0] bcd);
        t_exp_cal    r;
        longint      days;
        longint      yrs;
        longint      year_days;
        longint      scaled;
        longint      mon;
        longint      dom;
        r        = '0;
        r.hour   = decode_bcd_byte(bcd[23:16]);
        r.minute = decode_bcd_byte(bcd[15:8]);
        r.second = decode_bcd_byte(bcd[7:0]);
        days     = longint'(mjd);
        if (mjd >= MJD_FIRST_VALID) begin
            yrs       = (20 * days - 301564) / 7305;
            year_days = (1461 * yrs) / 4;
            scaled    = 10000 * (days - year_days);
            mon       = 0;
            if (scaled >= 149561000)
                mon = (scaled - 149561000) / 306001;
            dom = days - 14956 - year_days - (306001 * mon) / 10000;
            if (mon == 14 || mon == 15) begin
                r.year  = YR_W'(yrs + 1);
                r.month = MON_W'(mon - 13);
            end else begin
                r.year  = YR_W'(yrs);
                r.month = (mon >= 1) ? MON_W'(mon - 1) : '0;
            end
            r.day     = (dom > 0) ? DAY_W'(dom) : '0;
            r.date_ok = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input t_exp_cal want,
                                 input t_exp_cal got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t %s: exp y=%0d m=%0d d=%0d ok=%0b %0d:%0d:%0d",
                     $realtime, what,
                     want.year, want.month, want.day, want.date_ok,
                     want.hour, want.minute, want.second);
            $display("    got y=%0d m=%0d d=%0d ok=%0b %0d:%0d:%0d",
                     got.year, got.month, got.day, got.date_ok,
                     got.hour, got.minute, got.second);
        end
    endtask

    // result side: random stall, sampled values are pre-edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= !quiet_mode && ($urandom_range(0, 99) < 16);
        end
    end

    always @(posedge i_clk) begin
        t_exp_cal got;
        t_exp_cal want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_year_from_1900, o_month, o_day, o_date_valid,
                    o_hour, o_minute, o_second};
            if (pending_dates.size() == 0) begin
                note_mismatch("unexpected transaction", '0, got);
            end else begin
                want = pending_dates.pop_front();
                if (got !== want)
                    note_mismatch("field mismatch", want, got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_timestamp(input logic [MJD_W-1:0] mjd, input logic [TIME_W-1:0] bcd);
        while (!quiet_mode && ($urandom_range(0, 99) < 16)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mjd      <= mjd;
        i_bcd_time <= bcd;
        do @(posedge i_clk); while (o_stall);
        pending_dates.push_back(predict_calendar(mjd, bcd));
    endtask

    function automatic logic [MJD_W-1:0] pick_mjd();
        case ($urandom_range(0, 9))
            0: return MJD_W'($urandom_range(0, 15078));
            1: return MJD_W'($urandom_range(15060, 15100));
            2: return MJD_W'($urandom_range(65400, 65535));
            default: return MJD_W'($urandom_range(15079, 65535));
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] pick_time();
        logic [7:0] hh;
        logic [7:0] mm;
        logic [7:0] ss;
        if ($urandom_range(0, 1)) return TIME_W'($urandom);
        hh = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 9))};
        mm = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
        ss = {4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
        return {hh, mm, ss};
    endfunction

    // range limit, first valid day, leap day, year ends and the top of mjd
    task automatic test_date_edges();
        logic [MJD_W-1:0] dates[12] = '{16'd0, 16'd1, 16'd15078, 16'd15079, 16'd15080,
                                        16'd45000, 16'd51544, 16'd51603, 16'd51604,
                                        16'd51909, 16'd65534, 16'd65535};
        foreach (dates[i]) send_timestamp(dates[i], 24'h123456);
    endtask

    task automatic test_time_decoding();
        logic [TIME_W-1:0] times[9] = '{24'h000000, 24'h235959, 24'h999999, 24'hAAAAAA,
                                        24'hFFFFFF, 24'h0F0F0F, 24'hF0F0F0, 24'h9A9A9A,
                                        24'h120000};
        foreach (times[i]) send_timestamp(16'd58000, times[i]);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_timestamp(pick_mjd(), pick_time());
    endtask

    // sender holds off until the pipeline has fully drained
    task automatic test_drain_pause();
        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic test_unbroken_stream(input int count);
        quiet_mode = 1'b1;
        test_random_traffic(count);
        quiet_mode = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_date_edges();
        test_time_decoding();
        test_random_traffic(400);
        test_drain_pause();
        test_unbroken_stream(150);
        test_random_traffic(400);

        i_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
